### src/idle_timeout_packet_receiver_crc16_defines.svh
// Assertion macros shared by the idle timeout packet receiver.
`ifndef IDLE_TIMEOUT_PACKET_RECEIVER_CRC16_DEFINES_SVH
`define IDLE_TIMEOUT_PACKET_RECEIVER_CRC16_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define ITPRC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("itprc assertion failed");

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define ITPRC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("itprc assertion failed");

`endif

### src/itprc_pkg.sv
// Shared constants, types and the CRC step function of the packet receiver.
package itprc_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int IDX_W = 6;
    localparam logic [7:0] TIMEOUT_RESET = 8'd25;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [1:0] {
        ACT_BYTE    = 2'd0,
        ACT_TICK    = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_READ    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DRAIN,
        S_CHECK,
        S_POST
    } t_state;

    typedef struct packed {
        logic capture;
        logic wr_byte;
        logic tick;
        logic release_pkt;
        logic rd_req;
        logic scan_start;
        logic scan_step;
        logic check;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic close_due;
        logic scan_last;
    } t_dp_stat;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### src/idle_timeout_packet_receiver_crc16.sv
// Top level of the idle timeout packet receiver with CRC-16/XMODEM check.
//
// Each transaction carries one action (store a received byte, a millisecond
// tick, a host release, or a store read) and returns one result with the
// block status after that action. A byte, release, read or non-closing tick
// passes through the execute and post states from acceptance to a loaded
// result. A tick that closes a packet walks the packet's bytes in the 64-byte
// store through its single read port one byte per cycle into the CRC
// accumulator, then compares. The store is cleared at once through per-entry
// valid bits, so reset and flushes need no clearing pass. One transaction
// is processed at a time; a finished result waits in the output register
// while the next transaction is accepted.
`include "idle_timeout_packet_receiver_crc16_defines.svh"

module idle_timeout_packet_receiver_crc16 (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [7:0]                  i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_action,
    input  logic [7:0]                  i_rx_byte,
    input  logic [itprc_pkg::IDX_W-1:0] i_read_index,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [7:0]                  o_read_data,
    output logic                        o_packet_closed,
    output logic                        o_data_available,
    output logic [itprc_pkg::IDX_W-1:0] o_packet_length,
    output logic                        o_crc_match,
    output logic [15:0]                 o_computed_crc,
    output logic [15:0]                 o_carried_crc,
    output logic                        o_error_code,
    output logic                        o_timer_running
);
    import itprc_pkg::*;

    t_dp_cmd  s_cmd;
    t_dp_stat s_stat;

    itprc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_action(i_action),
        .i_stat  (s_stat),
        .o_cmd   (s_cmd)
    );

    itprc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_rx_byte       (i_rx_byte),
        .i_read_index    (i_read_index),
        .i_cmd           (s_cmd),
        .o_stat          (s_stat),
        .o_read_data     (o_read_data),
        .o_packet_closed (o_packet_closed),
        .o_data_available(o_data_available),
        .o_packet_length (o_packet_length),
        .o_crc_match     (o_crc_match),
        .o_computed_crc  (o_computed_crc),
        .o_carried_crc   (o_carried_crc),
        .o_error_code    (o_error_code),
        .o_timer_running (o_timer_running)
    );

    `ITPRC_ASSERT_NXT(a_accept_then_busy, i_valid && !o_stall, o_stall)
    `ITPRC_ASSERT_IMP(a_scan_while_busy, s_cmd.scan_step, o_stall && !s_cmd.load_out)
    `ITPRC_ASSERT_IMP(a_avail_needs_match, o_valid && o_data_available, o_crc_match)
    `ITPRC_ASSERT_IMP(a_close_stops_timer, o_valid && o_packet_closed, !o_timer_running)

endmodule

### src/itprc_ram.sv
// Generic single write port, single read port RAM with registered read data.
module itprc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/itprc_ctrl.sv
// Controller state machine: transaction handshake and datapath sequencing.
module itprc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    output logic                o_valid,
    input  logic                i_stall,
    input  logic [1:0]          i_action,
    input  itprc_pkg::t_dp_stat i_stat,
    output itprc_pkg::t_dp_cmd  o_cmd
);
    import itprc_pkg::*;

    t_state  r_state, n_state;
    t_action r_action, n_action;
    logic    r_out_valid, n_out_valid;
    t_dp_cmd s_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_action    <= ACT_BYTE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_action    <= n_action;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_action = r_action;
        s_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    s_cmd.capture = 1'b1;
                    n_action      = t_action'(i_action);
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_POST;
                case (r_action)
                    ACT_BYTE:    s_cmd.wr_byte = 1'b1;
                    ACT_TICK: begin
                        s_cmd.tick = 1'b1;
                        if (i_stat.close_due) begin
                            s_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    ACT_RELEASE: s_cmd.release_pkt = 1'b1;
                    ACT_READ:    s_cmd.rd_req = 1'b1;
                    default:     n_state = S_POST;
                endcase
            end
            S_SCAN: begin
                s_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                s_cmd.check = 1'b1;
                n_state     = S_POST;
            end
            S_POST: begin
                if (!r_out_valid || !i_stall) begin
                    s_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (s_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = s_cmd;

endmodule

### src/itprc_dp.sv
// Datapath: packet store, idle timer, CRC accumulator, flags and result register.
module itprc_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [7:0]                      i_cfg_wdata,
    input  logic [7:0]                      i_rx_byte,
    input  logic [itprc_pkg::IDX_W-1:0]     i_read_index,
    input  itprc_pkg::t_dp_cmd              i_cmd,
    output itprc_pkg::t_dp_stat             o_stat,
    output logic [7:0]                      o_read_data,
    output logic                            o_packet_closed,
    output logic                            o_data_available,
    output logic [itprc_pkg::IDX_W-1:0]     o_packet_length,
    output logic                            o_crc_match,
    output logic [15:0]                     o_computed_crc,
    output logic [15:0]                     o_carried_crc,
    output logic                            o_error_code,
    output logic                            o_timer_running
);
    import itprc_pkg::*;

    logic [7:0]             r_timeout;
    logic [7:0]             r_rx_byte;
    logic [IDX_W-1:0]       r_ridx;
    logic [ADDR_W-1:0]      r_wi;
    logic [STORE_DEPTH-1:0] r_vld;
    logic                   r_error;
    logic                   r_released;
    logic                   r_available;
    logic                   r_match;
    logic [15:0]            r_crc;
    logic [15:0]            r_carried;
    logic [7:0]             r_count;
    logic                   r_running;
    logic                   r_closed;
    logic                   r_rd_hit;
    logic                   r_q_ok;
    logic [ADDR_W-1:0]      r_scan_addr;
    logic                   r_feed_en;
    logic [ADDR_W-1:0]      r_feed_pos;

    logic [7:0]             r_o_read_data;
    logic                   r_o_closed;
    logic                   r_o_available;
    logic [IDX_W-1:0]       r_o_length;
    logic                   r_o_match;
    logic [15:0]            r_o_crc;
    logic [15:0]            r_o_carried;
    logic                   r_o_error;
    logic                   r_o_running;

    logic                   s_ram_we;
    logic                   s_ram_re;
    logic [ADDR_W-1:0]      s_raddr;
    logic [7:0]             s_ram_q;
    logic [7:0]             s_byte;
    logic                   s_timeout_hit;
    logic                   s_in_range;

    assign s_ram_we      = i_cmd.wr_byte && !r_error;
    assign s_ram_re      = i_cmd.rd_req || i_cmd.scan_step;
    assign s_raddr       = i_cmd.scan_step ? r_scan_addr : ADDR_W'(r_ridx);
    assign s_byte        = r_q_ok ? s_ram_q : 8'h00;
    assign s_timeout_hit = r_running && (r_count >= r_timeout);
    assign s_in_range    = (int'(r_ridx) < STORE_DEPTH);

    assign o_stat.close_due = s_timeout_hit && (r_wi != '0);
    assign o_stat.scan_last = (r_scan_addr == (r_wi - ADDR_W'(1)));

    itprc_ram #(
        .WIDTH(8),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (s_ram_we),
        .i_waddr(r_wi),
        .i_wdata(r_rx_byte),
        .i_re   (s_ram_re),
        .i_raddr(s_raddr),
        .o_rdata(s_ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rx_byte <= i_rx_byte;
            r_ridx    <= i_read_index;
        end
        if (s_ram_re) begin
            r_feed_pos <= r_scan_addr;
        end
        if (i_cmd.load_out) begin
            r_o_read_data <= (r_rd_hit && s_in_range) ? s_byte : 8'h00;
            r_o_closed    <= r_closed;
            r_o_available <= r_available;
            r_o_length    <= IDX_W'(r_wi);
            r_o_match     <= r_match;
            r_o_crc       <= r_crc;
            r_o_carried   <= r_carried;
            r_o_error     <= r_error;
            r_o_running   <= r_running;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RESET;
            r_wi        <= '0;
            r_vld       <= '0;
            r_error     <= 1'b0;
            r_released  <= 1'b0;
            r_available <= 1'b0;
            r_match     <= 1'b0;
            r_crc       <= '0;
            r_carried   <= '0;
            r_count     <= '0;
            r_running   <= 1'b0;
            r_closed    <= 1'b0;
            r_rd_hit    <= 1'b0;
            r_q_ok      <= 1'b0;
            r_scan_addr <= '0;
            r_feed_en   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (s_ram_re) begin
                r_q_ok <= r_vld[s_raddr];
            end
            r_feed_en <= i_cmd.scan_step;

            if (i_cmd.capture) begin
                r_closed <= 1'b0;
                r_rd_hit <= 1'b0;
            end
            if (i_cmd.rd_req) begin
                r_rd_hit <= 1'b1;
            end

            if (i_cmd.wr_byte) begin
                if (!r_error) begin
                    r_vld[r_wi] <= 1'b1;
                    if (int'(r_wi) == STORE_DEPTH - 1) begin
                        r_wi <= '0;
                    end else begin
                        r_wi <= r_wi + ADDR_W'(1);
                    end
                end
                r_count   <= '0;
                r_running <= 1'b1;
            end

            if (i_cmd.tick && r_running) begin
                if (s_timeout_hit) begin
                    r_running <= 1'b0;
                    r_count   <= '0;
                end else begin
                    r_count <= r_count + 8'd1;
                end
            end

            if (i_cmd.release_pkt) begin
                r_vld       <= '0;
                r_wi        <= '0;
                r_available <= 1'b0;
                r_released  <= 1'b1;
                r_error     <= 1'b0;
            end

            if (i_cmd.scan_start) begin
                r_closed    <= 1'b1;
                r_crc       <= '0;
                r_carried   <= '0;
                r_scan_addr <= '0;
                if (!r_released) begin
                    r_error <= 1'b1;
                end
            end

            if (i_cmd.scan_step) begin
                r_scan_addr <= r_scan_addr + ADDR_W'(1);
            end

            if (r_feed_en) begin
                if (({1'b0, r_feed_pos} + (ADDR_W + 1)'(2)) < {1'b0, r_wi}) begin
                    r_crc <= crc_feed(r_crc, s_byte);
                end else if (r_wi >= ADDR_W'(2)) begin
                    r_carried <= {r_carried[7:0], s_byte};
                end
            end

            if (i_cmd.check) begin
                r_released <= 1'b0;
                if (r_crc == r_carried) begin
                    r_match     <= 1'b1;
                    r_available <= 1'b1;
                end else begin
                    r_match     <= 1'b0;
                    r_vld       <= '0;
                    r_wi        <= '0;
                    r_available <= 1'b0;
                    r_error     <= 1'b0;
                end
            end
        end
    end

    assign o_read_data      = r_o_read_data;
    assign o_packet_closed  = r_o_closed;
    assign o_data_available = r_o_available;
    assign o_packet_length  = r_o_length;
    assign o_crc_match      = r_o_match;
    assign o_computed_crc   = r_o_crc;
    assign o_carried_crc    = r_o_carried;
    assign o_error_code     = r_o_error;
    assign o_timer_running  = r_o_running;

endmodule
